### rtl/core/cemg_pkg.sv
`default_nettype none
package cemg_pkg;

	// fixed field widths of the stream channels
	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 3;
	localparam int S_DATA_W = 2 * NUM_CHAN * CHAN_W;
	localparam int GRAD_W = 8;
	localparam int M_DATA_W = GRAD_W;
	localparam logic [GRAD_W-1:0] GRAD_MAX = 8'd255;

	// defaults for the top level parameters
	localparam int CHANNEL_BITS_DEF = 8;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// back part sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_HOLD
	} bk_state_t;

endpackage
`default_nettype wire

### rtl/core/cemg_front.sv
`default_nettype none
module cemg_front #(
	parameter int CHANNEL_BITS = cemg_pkg::CHANNEL_BITS_DEF,
	parameter int SUM_W = 2 * CHANNEL_BITS + 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [cemg_pkg::S_DATA_W-1:0] in_data,
	input  wire logic                        in_last,
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output logic [SUM_W-1:0]                 push_data
);
	import cemg_pkg::*;

	localparam int CW = CHANNEL_BITS;
	localparam int SQ_W = 2 * CW;

	logic [NUM_CHAN-1:0][CW-1:0]   cen_w;
	logic [NUM_CHAN-1:0][CW-1:0]   nbr_w;
	logic [NUM_CHAN-1:0][CW-1:0]   diff_w;
	logic [NUM_CHAN-1:0][SQ_W-1:0] sq_w;
	logic [NUM_CHAN-1:0][SQ_W-1:0] sq_s1;
	logic                          valid_s1;
	logic                          last_s1;
	logic [SUM_W-1:0]              max_q;
	logic [SUM_W-1:0]              sum_w;
	logic [SUM_W-1:0]              cand_w;
	logic                          adv_w;

	// channel fields, masked or zero-extended to the working width
	for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
		for (genvar b = 0; b < CW; b++) begin : g_bit
			if (b < CHAN_W) begin : g_in
				assign cen_w[k][b] = in_data[k*CHAN_W + b];
				assign nbr_w[k][b] = in_data[(NUM_CHAN + k)*CHAN_W + b];
			end else begin : g_zero
				assign cen_w[k][b] = 1'b0;
				assign nbr_w[k][b] = 1'b0;
			end
		end
	end

	// absolute differences and their squares
	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			diff_w[k] = (cen_w[k] >= nbr_w[k]) ? (cen_w[k] - nbr_w[k]) : (nbr_w[k] - cen_w[k]);
			sq_w[k] = SQ_W'(diff_w[k]) * SQ_W'(diff_w[k]);
		end
	end

	// stage two: sum and running maximum
	assign sum_w = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
	assign cand_w = (sum_w > max_q) ? sum_w : max_q;

	// a final neighbor waits in stage one until the queue takes it
	assign push_valid = valid_s1 & last_s1;
	assign push_data = cand_w;
	assign adv_w = ~valid_s1 | ~last_s1 | push_ready;
	assign in_ready = adv_w;

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_w) begin
			valid_s1 <= in_valid;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (adv_w && in_valid) begin
			sq_s1 <= sq_w;
			last_s1 <= in_last;
		end
	end

	// running maximum, cleared when a group closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (valid_s1 && adv_w) begin
			max_q <= last_s1 ? '0 : cand_w;
		end
	end

endmodule
`default_nettype wire

### rtl/core/cemg_queue.sv
`default_nettype none
module cemg_queue #(
	parameter int DATA_W = 18
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output logic [DATA_W-1:0]      rd_data
);
	import cemg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push_w;
	logic              pop_w;

	assign wr_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign push_w = wr_valid & wr_ready;
	assign pop_w = rd_valid & rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_w) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_w) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_w && !pop_w) begin
				count_q <= count_q + 1'b1;
			end else if (pop_w && !push_w) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push_w) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

### rtl/core/cemg_back.sv
`default_nettype none
module cemg_back #(
	parameter int CHANNEL_BITS = cemg_pkg::CHANNEL_BITS_DEF,
	parameter int SUM_W = 2 * CHANNEL_BITS + 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pop_valid,
	output logic                            pop_ready,
	input  wire logic [SUM_W-1:0]           pop_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [cemg_pkg::GRAD_W-1:0]     out_data
);
	import cemg_pkg::*;

	localparam int CW = CHANNEL_BITS;
	localparam int ROOT_W = CW + 1;
	localparam int SREM_W = CW + 3;
	localparam int CNT_W = $clog2(SUM_W / 2);
	localparam int XW = (ROOT_W > GRAD_W) ? ROOT_W : GRAD_W;
	localparam int PROD_W = 2 * SUM_W;
	// ceil(2^(SUM_W+1) / 3), exact floor(x / 3) for every SUM_W-bit x
	localparam logic [SUM_W-1:0] DIV3_M = SUM_W'(((64'd1 << (SUM_W + 1)) + 64'd2) / 64'd3);

	bk_state_t         state_q;
	bk_state_t         state_nxt;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  dq_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_q;
	logic [GRAD_W-1:0] out_q;
	logic              out_valid_q;
	logic              load_out;
	logic              sqrt_last;
	logic [PROD_W-1:0] prod_w;
	logic [SUM_W-1:0]  quot_w;
	logic [SREM_W-1:0] srem_n_w;
	logic [SREM_W-1:0] strial_w;
	logic              sge_w;
	logic [XW-1:0]     xroot_w;
	logic [GRAD_W-1:0] grad_w;

	assign sqrt_last = (cnt_q == CNT_W'(SUM_W / 2 - 1));

	// sequencer: divide by three in one multiply, then root two bits a step
	always_comb begin
		state_nxt = state_q;
		pop_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_nxt = BK_DIV;
				end
			end
			BK_DIV: begin
				state_nxt = BK_SQRT;
			end
			BK_SQRT: begin
				if (sqrt_last) begin
					state_nxt = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// division by three as a reciprocal multiply and shift
	assign prod_w = PROD_W'(dq_q) * PROD_W'(DIV3_M);
	assign quot_w = {1'b0, prod_w[PROD_W-1:SUM_W+1]};

	// digit-by-digit square root step
	assign srem_n_w = {srem_q[SREM_W-3:0], dq_q[SUM_W-1:SUM_W-2]};
	assign strial_w = {root_q, 2'b01};
	assign sge_w = (srem_n_w >= strial_w);

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				dq_q <= pop_data;
				cnt_q <= '0;
			end
			BK_DIV: begin
				dq_q <= quot_w;
				cnt_q <= '0;
				root_q <= '0;
				srem_q <= '0;
			end
			BK_SQRT: begin
				srem_q <= sge_w ? (srem_n_w - strial_w) : srem_n_w;
				root_q <= {root_q[ROOT_W-2:0], sge_w};
				dq_q <= {dq_q[SUM_W-3:0], 2'b00};
				cnt_q <= cnt_q + 1'b1;
			end
			BK_HOLD: begin
				cnt_q <= '0;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	// saturate the root to the gradient range
	assign xroot_w = XW'(root_q);
	assign grad_w = (xroot_w > XW'(GRAD_MAX)) ? GRAD_MAX : xroot_w[GRAD_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= grad_w;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

### rtl/core/color_euclidean_morph_gradient_unit.sv
// Color morphological gradient, Euclidean form.
// Slave stream: one transaction per neighbor of the structuring element,
// carrying the center pixel, the neighbor pixel and tlast on the final
// neighbor. Master stream: one 8-bit gradient per center pixel, equal to
// floor(sqrt(max / 3)) of the largest squared channel-difference sum.
// Neighbors are taken one per cycle unless a final neighbor waits on a
// full queue; the front squares and sums them in two register stages
// and keeps the running maximum. A closed group goes through a two-entry
// queue to the back, which takes one entry at a time: it pops the sum,
// divides by three with one reciprocal multiply, takes the root two bits
// a cycle, then loads the gradient into the output register before it
// pops the next entry.
// Groups that arrive faster than the back finishes results fill the queue;
// the slave side then stalls only on a final neighbor while the queue is
// full.
// A stalled master side holds the gradient in the output register while
// the back already works on the next group.
// Reset clears the running maximum, the queue and the sequencer.
`default_nettype none
module color_euclidean_morph_gradient_unit #(
	parameter int CHANNEL_BITS = cemg_pkg::CHANNEL_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// center_chan0, center_chan1, center_chan2,
	// neighbor_chan0, neighbor_chan1, neighbor_chan2
	input  wire logic [cemg_pkg::S_DATA_W-1:0] s_tdata,
	input  wire logic                         s_tlast,   // last_neighbor
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// gradient
	output logic [cemg_pkg::M_DATA_W-1:0]     m_tdata
);
	import cemg_pkg::*;

	localparam int SUM_W = 2 * CHANNEL_BITS + 2;

	logic             push_valid;
	logic             push_ready;
	logic [SUM_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [SUM_W-1:0] pop_data;

	cemg_front #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.SUM_W(SUM_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_data(s_tdata),
		.in_last(s_tlast),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	cemg_queue #(
		.DATA_W(SUM_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data(push_data),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data(pop_data)
	);

	cemg_back #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.SUM_W(SUM_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

	// slave side stalls only behind a final neighbor the queue cannot take
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (push_valid && !push_ready))
		else $error("slave stall without a blocked queue push");

	// a blocked push keeps waiting
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> push_valid)
		else $error("queue push dropped while blocked");

	// back takes one queue entry and is then busy
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> !pop_ready)
		else $error("back took a second entry while busy");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import cemg_pkg::*;

	localparam int CHAN_MAX = (1 << CHAN_W) - 1;
	localparam int SUM_W = 2 * CHAN_W + 2;
	localparam int ITEM_TARGET = 1550;

	// one pixel, channel 0 in the lowest bits
	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

	// one neighbor transaction plus the idle cycles that follow it
	typedef struct packed {
		logic [4:0] gap;
		logic       last;
		pixel_t     nbr;
		pixel_t     ctr;
	} nbr_txn_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	nbr_txn_t            nbr_txn_q[$];
	logic [GRAD_W-1:0]   grad_expect_q[$];
	logic [SUM_W-1:0]    peak_sum = '0;
	int                  grad_mismatches = 0;
	int                  grads_seen = 0;
	bit                  burst_in = 1'b0;
	bit                  s_fire = 1'b0;
	bit                  m_fire = 1'b0;
	int                  in_gap = 0;
	int                  out_stall = 0;

	color_euclidean_morph_gradient_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// sum of squared channel differences
	function automatic int sq_dist(pixel_t a, pixel_t b);
		int acc;
		int d;
		acc = 0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			d = int'(a[k]) - int'(b[k]);
			acc += d * d;
		end
		return acc;
	endfunction

	// floor(sqrt(peak / 3)), built bit by bit from the top
	function automatic logic [GRAD_W-1:0] gradient_of(logic [SUM_W-1:0] peak);
		int mean;
		int root;
		int trial;
		mean = peak / 3;
		root = 0;
		for (int b = CHAN_W; b >= 0; b--) begin
			trial = root | (1 << b);
			if (trial * trial <= mean) root = trial;
		end
		if (root > GRAD_MAX) root = GRAD_MAX;
		return root[GRAD_W-1:0];
	endfunction

	// pixel within +-spread of c per channel, clipped to the channel range
	function automatic pixel_t near_px(pixel_t c, int spread);
		pixel_t p;
		int v;
		for (int k = 0; k < NUM_CHAN; k++) begin
			v = int'(c[k]) + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0) v = 0;
			if (v > CHAN_MAX) v = CHAN_MAX;
			p[k] = v[CHAN_W-1:0];
		end
		return p;
	endfunction

	task automatic push_nbr(pixel_t c, pixel_t n, logic last);
		nbr_txn_t t;
		t.ctr = c;
		t.nbr = n;
		t.last = last;
		t.gap = burst_in ? 5'd0 : 5'($urandom_range(0, 19));
		nbr_txn_q.push_back(t);
	endtask

	task automatic note_mismatch(string msg);
		grad_mismatches++;
		if (grad_mismatches <= 10) $display("mismatch: %s", msg);
	endtask

	// slave side driver, fed from the neighbor queue
	always @(negedge clk) begin : nbr_driver
		nbr_txn_t t;
		if (arst_n && !(s_tvalid && !s_fire)) begin
			if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (nbr_txn_q.size() != 0) begin
				t = nbr_txn_q.pop_front();
				s_tdata <= {t.nbr, t.ctr};
				s_tlast <= t.last;
				s_tvalid <= 1'b1;
				in_gap = t.gap;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// master side ready, with stall stretches and stall-free stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_fire)
				out_stall = ((grads_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, 19);
			if (out_stall > 0) begin
				m_tready <= 1'b0;
				out_stall = out_stall - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: check gradients, predict from accepted neighbors
	always @(posedge clk) begin : grad_monitor
		logic [GRAD_W-1:0] want;
		logic [SUM_W-1:0]  sq_sum;
		pixel_t            ctr;
		pixel_t            nbr;
		if (arst_n) begin
			s_fire <= s_tvalid && s_tready;
			m_fire <= m_tvalid && m_tready;
			if (m_tvalid && m_tready) begin
				grads_seen++;
				if (grad_expect_q.size() == 0) begin
					note_mismatch($sformatf("unexpected gradient %0d", m_tdata));
				end else begin
					want = grad_expect_q.pop_front();
					if (m_tdata !== want)
						note_mismatch($sformatf("gradient expected %0d got %0d",
							want, m_tdata));
				end
			end
			if (s_tvalid && s_tready) begin
				ctr = s_tdata[NUM_CHAN*CHAN_W-1:0];
				nbr = s_tdata[S_DATA_W-1:NUM_CHAN*CHAN_W];
				sq_sum = SUM_W'(sq_dist(ctr, nbr));
				if (sq_sum > peak_sum) peak_sum = sq_sum;
				if (s_tlast) begin
					grad_expect_q.push_back(gradient_of(peak_sum));
					peak_sum = '0;
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin : stim
		pixel_t ctr;
		pixel_t nbr;
		int     glen;
		int     spread_kind;
		bit     wander;

		out_stall = $urandom_range(0, 19);

		// single neighbors at the channel extremes and at mid-scale
		push_nbr(24'h000000, 24'hFFFFFF, 1'b1);
		push_nbr(24'hFFFFFF, 24'h000000, 1'b1);
		push_nbr(24'h808080, 24'h808080, 1'b1);
		push_nbr(24'h000000, 24'h0000FF, 1'b1);
		push_nbr(24'h000000, 24'h00FF00, 1'b1);
		push_nbr(24'hFF0000, 24'h000000, 1'b1);
		// all neighbors equal to the center
		push_nbr(24'h123456, 24'h123456, 1'b0);
		push_nbr(24'h123456, 24'h123456, 1'b0);
		push_nbr(24'h123456, 24'h123456, 1'b1);
		// largest difference first, then smaller ones
		push_nbr(24'h000000, 24'h202020, 1'b0);
		push_nbr(24'h000000, 24'h010101, 1'b0);
		push_nbr(24'h000000, 24'h000000, 1'b1);
		// center changes inside one group
		push_nbr(24'hAAAAAA, 24'h555555, 1'b0);
		push_nbr(24'h555555, 24'h555555, 1'b0);
		push_nbr(24'h0F0F0F, 24'hF0F0F0, 1'b1);
		// alternating bit patterns and tiny sums
		push_nbr(24'h55AA55, 24'hAA55AA, 1'b1);
		push_nbr(24'h010203, 24'h030201, 1'b1);
		push_nbr(24'h000000, 24'h000001, 1'b1);

		// random groups: mostly short, a few long, with varied spreads
		while (nbr_txn_q.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 29) == 0) burst_in = ~burst_in;
			glen = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
				$urandom_range(1, 9);
			ctr = pixel_t'($urandom);
			spread_kind = $urandom_range(0, 3);
			wander = ($urandom_range(0, 4) == 0);
			for (int j = 0; j < glen; j++) begin
				if (wander && $urandom_range(0, 2) == 0) ctr = pixel_t'($urandom);
				case (spread_kind)
					0: nbr = $urandom_range(0, 1) ? ctr : near_px(ctr, 2);
					1: nbr = near_px(ctr, 12);
					2: nbr = near_px(ctr, 60);
					default: nbr = pixel_t'($urandom);
				endcase
				push_nbr(ctr, nbr, j == glen - 1);
			end
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (nbr_txn_q.size() != 0 || s_tvalid) @(posedge clk);
		while (grad_expect_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (grad_mismatches == 0 && grad_expect_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### color_euclidean_morph_gradient_unit.f
rtl/core/cemg_pkg.sv
rtl/core/cemg_front.sv
rtl/core/cemg_queue.sv
rtl/core/cemg_back.sv
rtl/core/color_euclidean_morph_gradient_unit.sv
tb/tb.sv
